@@ src/sfhp_pkg.sv @@
// shared types, constants and result builders for the sync frame header parser
`timescale 1ns / 1ps
`default_nettype none

package sfhp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h40;
    localparam logic [7:0] SYNC_SECOND = 8'h54;
    localparam logic [7:0] SERIAL_MOD  = 8'h80;

    localparam logic [15:0] MIN_VERSION_RST  = 16'd1;
    localparam logic [11:0] MAX_DATA_LEN_RST = 12'd2048;

    localparam logic REG_MIN_VERSION  = 1'b0;
    localparam logic REG_MAX_DATA_LEN = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [15:0] {
        PH_HUNT    = 16'h0001,
        PH_SYNC2   = 16'h0002,
        PH_VER0    = 16'h0004,
        PH_VER1    = 16'h0008,
        PH_LEN0    = 16'h0010,
        PH_LEN1    = 16'h0020,
        PH_SERIAL  = 16'h0040,
        PH_FEAT0   = 16'h0080,
        PH_FEAT1   = 16'h0100,
        PH_CMD     = 16'h0200,
        PH_MODE    = 16'h0400,
        PH_PAYLOAD = 16'h0800,
        PH_SUM0    = 16'h1000,
        PH_SUM1    = 16'h2000,
        PH_SUM2    = 16'h4000,
        PH_SUM3    = 16'h8000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [10:0] data_index;
        logic [15:0] source_version;
        logic [15:0] feature_word;
        logic [7:0]  command;
        logic [7:0]  mode_byte;
        logic [7:0]  serial;
        logic [11:0] payload_len;
        logic [31:0] checksum;
        logic        version_error;
        logic        lost_error;
    } t_result;

    // results made by one accepted item, rec0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    rec0;
        t_result    rec1;
    } t_push;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

    function automatic t_result make_payload(input logic [7:0] b, input logic [10:0] idx);
        t_result r;
        r            = '0;
        r.kind       = KIND_PAYLOAD;
        r.data_byte  = b;
        r.data_index = idx;
        return r;
    endfunction

    function automatic t_result make_summary(
        input logic [15:0] ver,
        input logic [15:0] feat,
        input logic [7:0]  cmd,
        input logic [7:0]  mode,
        input logic [7:0]  ser,
        input logic [11:0] len,
        input logic [31:0] sum,
        input logic [1:0]  errs
    );
        t_result r;
        r                = '0;
        r.kind           = KIND_SUMMARY;
        r.source_version = ver;
        r.feature_word   = feat;
        r.command        = cmd;
        r.mode_byte      = mode;
        r.serial         = ser;
        r.payload_len    = len;
        r.checksum       = mode[0] ? sum : 32'h0;
        r.version_error  = errs[0];
        r.lost_error     = errs[1];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/sfhp_parser.sv @@
// byte-wise frame parser: phase register, header capture and result building
`timescale 1ns / 1ps
`default_nettype none

module sfhp_parser
    import sfhp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_acc,
    input  wire         i_op,
    input  wire  [7:0]  i_rx_byte,
    input  wire  [15:0] i_min_version,
    input  wire  [11:0] i_max_data_len,
    output t_push       o_push
);

    t_phase      r_phase,   n_phase;
    logic [11:0] r_count,   n_count;
    logic [15:0] r_version, n_version;
    logic [11:0] r_length,  n_length;
    logic [7:0]  r_serial,  n_serial;
    logic [15:0] r_feature, n_feature;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_mode,    n_mode;
    logic [23:0] r_sum,     n_sum;
    logic [7:0]  r_prev,    n_prev;
    logic        r_first,   n_first;
    logic [1:0]  r_err,     n_err;

    logic [15:0] full_len;
    logic [7:0]  serial_inc;
    logic [7:0]  serial_exp;

    assign full_len   = {i_rx_byte, r_length[7:0]};
    assign serial_inc = r_prev + 8'd1;
    assign serial_exp = serial_inc & (SERIAL_MOD - 8'd1);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_version = r_version;
        n_length  = r_length;
        n_serial  = r_serial;
        n_feature = r_feature;
        n_command = r_command;
        n_mode    = r_mode;
        n_sum     = r_sum;
        n_prev    = r_prev;
        n_first   = r_first;
        n_err     = r_err;
        o_push    = '0;
        if (i_acc) begin
            if (i_op) begin
                n_first = 1'b1;
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        n_err   = 2'b00;
                        n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                    end
                    PH_SYNC2: begin
                        n_phase = (i_rx_byte == SYNC_SECOND) ? PH_VER0 : PH_HUNT;
                    end
                    PH_VER0: begin
                        n_version = {8'h00, i_rx_byte};
                        n_phase   = PH_VER1;
                    end
                    PH_VER1: begin
                        n_version = {i_rx_byte, r_version[7:0]};
                        if (n_version < i_min_version) begin
                            n_err[0] = 1'b1;
                        end
                        n_phase = PH_LEN0;
                    end
                    PH_LEN0: begin
                        n_length = {4'h0, i_rx_byte};
                        n_phase  = PH_LEN1;
                    end
                    PH_LEN1: begin
                        // oversize frames vanish without a summary
                        if (full_len > {4'h0, i_max_data_len}) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_length = full_len[11:0];
                            n_phase  = PH_SERIAL;
                        end
                    end
                    PH_SERIAL: begin
                        n_serial = i_rx_byte;
                        if (r_first) begin
                            n_first = 1'b0;
                        end else if (i_rx_byte != serial_exp) begin
                            n_err[1] = 1'b1;
                        end
                        n_prev  = i_rx_byte;
                        n_phase = PH_FEAT0;
                    end
                    PH_FEAT0: begin
                        n_feature = {8'h00, i_rx_byte};
                        n_phase   = PH_FEAT1;
                    end
                    PH_FEAT1: begin
                        n_feature = {i_rx_byte, r_feature[7:0]};
                        n_phase   = PH_CMD;
                    end
                    PH_CMD: begin
                        n_command = i_rx_byte;
                        n_phase   = PH_MODE;
                    end
                    PH_MODE: begin
                        n_mode = i_rx_byte;
                        n_sum  = 24'h0;
                        if (r_length != 12'd0) begin
                            n_count = 12'd0;
                            n_phase = PH_PAYLOAD;
                        end else if (i_rx_byte[0]) begin
                            n_phase = PH_SUM0;
                        end else begin
                            o_push.cnt  = 2'd1;
                            o_push.rec0 = make_summary(r_version, r_feature, r_command,
                                i_rx_byte, r_serial, r_length, 32'h0, r_err);
                            n_phase     = PH_HUNT;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_push.cnt  = 2'd1;
                        o_push.rec0 = make_payload(i_rx_byte, r_count[10:0]);
                        n_count     = r_count + 12'd1;
                        if (n_count == r_length) begin
                            if (r_mode[0]) begin
                                n_phase = PH_SUM0;
                            end else begin
                                // last byte without checksum: byte and summary together
                                o_push.cnt  = 2'd2;
                                o_push.rec1 = make_summary(r_version, r_feature, r_command,
                                    r_mode, r_serial, r_length, 32'h0, r_err);
                                n_phase     = PH_HUNT;
                            end
                        end
                    end
                    PH_SUM0: begin
                        n_sum   = {16'h0, i_rx_byte};
                        n_phase = PH_SUM1;
                    end
                    PH_SUM1: begin
                        n_sum   = {8'h0, i_rx_byte, r_sum[7:0]};
                        n_phase = PH_SUM2;
                    end
                    PH_SUM2: begin
                        n_sum   = {i_rx_byte, r_sum[15:0]};
                        n_phase = PH_SUM3;
                    end
                    PH_SUM3: begin
                        o_push.cnt  = 2'd1;
                        o_push.rec0 = make_summary(r_version, r_feature, r_command,
                            r_mode, r_serial, r_length, {i_rx_byte, r_sum}, r_err);
                        n_phase     = PH_HUNT;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= 12'd0;
            r_version <= 16'd0;
            r_length  <= 12'd0;
            r_serial  <= 8'd0;
            r_feature <= 16'd0;
            r_command <= 8'd0;
            r_mode    <= 8'd0;
            r_sum     <= 24'd0;
            r_prev    <= 8'd0;
            r_first   <= 1'b1;
            r_err     <= 2'b00;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_version <= n_version;
            r_length  <= n_length;
            r_serial  <= n_serial;
            r_feature <= n_feature;
            r_command <= n_command;
            r_mode    <= n_mode;
            r_sum     <= n_sum;
            r_prev    <= n_prev;
            r_first   <= n_first;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ src/sfhp_out_fifo.sv @@
// result queue: takes up to two results a cycle, hands out one a cycle if not stalled
`timescale 1ns / 1ps
`default_nettype none

module sfhp_out_fifo
    import sfhp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_push       i_push,
    input  wire         i_stall,
    output logic        o_valid,
    output t_result     o_rec,
    output t_fifo_stat  o_stat
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count,  n_count;
    logic [FIFO_AW-1:0] wr_ptr_1;
    logic               pop;

    assign o_valid  = (r_count != '0);
    assign o_rec    = r_mem[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    assign wr_ptr_1 = r_wr_ptr + FIFO_AW'(1);

    assign n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
    assign n_count  = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop);

    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ src/sync_frame_header_parser.sv @@
// a result is registered in the result queue as the byte that causes it is accepted
// throughput: one byte per cycle when not stalled; the last payload byte of a
// frame without checksum yields two results, buffered in a four-entry result queue
// input stalls while the queue holds more than two results
// synchronous active-low reset empties the queue, restarts the sync hunt, arms the
// first-frame serial skip and sets min_version to 1 and max_data_len to 2048
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_header_parser
    import sfhp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_op,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [10:0] o_data_index,
    output logic [15:0] o_source_version,
    output logic [15:0] o_feature_word,
    output logic [7:0]  o_command,
    output logic [7:0]  o_mode_byte,
    output logic [7:0]  o_serial,
    output logic [11:0] o_payload_len,
    output logic [31:0] o_checksum,
    output logic        o_version_error,
    output logic        o_lost_error
);

    logic [15:0] r_min_version;
    logic [11:0] r_max_data_len;
    logic        in_acc;
    t_push       push;
    t_result     rec;
    t_fifo_stat  fstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_version  <= MIN_VERSION_RST;
            r_max_data_len <= MAX_DATA_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_VERSION:  r_min_version  <= i_cfg_data;
                REG_MAX_DATA_LEN: r_max_data_len <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // room for two results must remain before a byte is taken
    assign o_stall = (fstat.count > FIFO_CW'(FIFO_DEPTH - 2));
    assign in_acc  = i_valid && !o_stall;

    sfhp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (in_acc),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .i_min_version  (r_min_version),
        .i_max_data_len (r_max_data_len),
        .o_push         (push)
    );

    sfhp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rec   (rec),
        .o_stat  (fstat)
    );

    assign o_kind           = rec.kind;
    assign o_data_byte      = rec.data_byte;
    assign o_data_index     = rec.data_index;
    assign o_source_version = rec.source_version;
    assign o_feature_word   = rec.feature_word;
    assign o_command        = rec.command;
    assign o_mode_byte      = rec.mode_byte;
    assign o_serial         = rec.serial;
    assign o_payload_len    = rec.payload_len;
    assign o_checksum       = rec.checksum;
    assign o_version_error  = rec.version_error;
    assign o_lost_error     = rec.lost_error;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |-> in_acc)
        else $error("result pushed without an input transfer");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd3)
        else $error("more than two results from one byte");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_data_byte == 8'd0 && o_data_index == 11'd0))
        else $error("summary carries payload data");

    a_valid_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0) |=> o_valid)
        else $error("pushed result not offered");
`endif

endmodule

`default_nettype wire
